@@ rtl/accumulator_cpu_step_defines.svh @@
// assertion macros used by the accumulator machine top level
`ifndef ACCUMULATOR_CPU_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_DEFINES_SVH
`ifndef SYNTH
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/acs_pkg.sv @@
// types, codes and helpers of the accumulator machine
package acs_pkg;

    localparam int unsigned MEM_DEPTH_DEF = 256;
    localparam int unsigned DATA_W        = 8;
    localparam int unsigned ADDR_W        = 8;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [7:0] OP_LDI = 8'd1;
    localparam logic [7:0] OP_LDM = 8'd2;
    localparam logic [7:0] OP_STA = 8'd3;
    localparam logic [7:0] OP_ADI = 8'd4;
    localparam logic [7:0] OP_ADM = 8'd5;
    localparam logic [7:0] OP_SBI = 8'd6;
    localparam logic [7:0] OP_SBM = 8'd7;
    localparam logic [7:0] OP_JMP = 8'd8;
    localparam logic [7:0] OP_JZ  = 8'd9;
    localparam logic [7:0] OP_OUT = 8'd10;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic              printed;
        logic [DATA_W-1:0] printed_value;
        logic              halted;
        logic [ADDR_W-1:0] program_counter;
        logic [DATA_W-1:0] accumulator;
    } t_rsp;

    typedef struct packed {
        logic we;
        logic re_a;
        logic re_b;
    } t_mem_ctl;

    // byte address reduced modulo the memory depth (depth of at least 16)
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a,
                                                    input int unsigned depth);
        logic [11:0] r;
        logic [11:0] d;
        r = 12'(a);
        for (int k = 3; k >= 0; k--) begin
            d = 12'(depth) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/acs_if.sv @@
// request and result channels of the accumulator machine
interface acs_req_if;
    logic         valid;
    logic         ready;
    acs_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface acs_rsp_if;
    logic         valid;
    logic         ready;
    acs_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/acs_mem.sv @@
// unified byte memory, one write and two registered read ports, zero until written
module acs_mem #(
    parameter int unsigned DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acs_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [acs_pkg::DATA_W-1:0]   i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_b,
    output logic [acs_pkg::DATA_W-1:0]   o_rdata_a,
    output logic [acs_pkg::DATA_W-1:0]   o_rdata_b
);

    logic [acs_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [acs_pkg::DATA_W-1:0] r_rd_a;
    logic [acs_pkg::DATA_W-1:0] r_rd_b;
    logic                       r_va;
    logic                       r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re_a) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_va   <= r_valid[i_raddr_a];
        end
        if (i_ctl.re_b) begin
            r_rd_b <= r_mem[i_raddr_b];
            r_vb   <= r_valid[i_raddr_b];
        end
    end

    // entries never written read as zero
    assign o_rdata_a = r_va ? r_rd_a : '0;
    assign o_rdata_b = r_vb ? r_rd_b : '0;

endmodule

@@ rtl/accumulator_cpu_step.sv @@
// top level of the accumulator machine
// Each request returns one result. Write, restart and unused commands, and an
// execute while halted, take one cycle each and can follow one another every
// cycle. An execute runs through the fetch and execute states: opcode and operand
// are read together from two ports of the byte memory as the request is taken,
// then the operand address is read (or the store is written), then the
// instruction completes and its result is registered, as a chain of dependent
// reads through the synchronous memory. The next request is taken in the cycle
// a result is produced, provided the result register is free. Memory entries
// carry valid bits cleared by reset, so there is no clearing pass after reset.
`include "accumulator_cpu_step_defines.svh"

module accumulator_cpu_step #(
    parameter int unsigned MEM_DEPTH = acs_pkg::MEM_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acs_req_if.sink   i_req,
    acs_rsp_if.source o_rsp
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_POST
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_pc;
    logic [7:0]                 r_acc;
    logic                       r_halt;
    logic [7:0]                 r_op;
    logic [7:0]                 r_opnd;
    logic                       r_o_valid;
    acs_pkg::t_rsp              r_o_data;

    acs_pkg::t_req              req;
    acs_pkg::t_mem_ctl          mem_ctl;
    logic [AW-1:0]              mem_waddr;
    logic [7:0]                 mem_wdata;
    logic [AW-1:0]              mem_raddr_a;
    logic [AW-1:0]              mem_raddr_b;
    logic [7:0]                 rd_a;
    logic [7:0]                 rd_b;

    logic                       accept;
    logic                       run;
    logic                       restart;
    logic                       out_free;
    logic                       out_load;
    logic                       op_legal;
    logic [AW-1:0]              ea;
    logic [AW-1:0]              n_pc;
    logic [7:0]                 n_acc;
    logic                       x_printed;
    logic [7:0]                 x_pval;
    acs_pkg::t_rsp              x_rsp;
    acs_pkg::t_rsp              s_rsp;

    function automatic logic [AW-1:0] pc_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign req      = i_req.data;
    assign out_free = !r_o_valid || o_rsp.ready;
    assign out_load = out_free && ((r_state == S_EXEC) || (r_state == S_POST));
    assign i_req.ready = (r_state == S_IDLE)
                       || (((r_state == S_EXEC) || (r_state == S_POST)) && out_free);
    assign accept   = i_req.valid && i_req.ready;
    assign run      = accept && (req.cmd == acs_pkg::CMD_EXEC) && !r_halt;
    assign restart  = accept && (req.cmd == acs_pkg::CMD_RESTART);

    // fetch stage decode
    assign ea = AW'(acs_pkg::wrap_addr(rd_b, MEM_DEPTH));

    always_comb begin
        case (rd_a) inside
            acs_pkg::OP_LDI, acs_pkg::OP_LDM, acs_pkg::OP_STA, acs_pkg::OP_ADI,
            acs_pkg::OP_ADM, acs_pkg::OP_SBI, acs_pkg::OP_SBM, acs_pkg::OP_JMP,
            acs_pkg::OP_JZ, acs_pkg::OP_OUT: op_legal = 1'b1;
            default:                         op_legal = 1'b0;
        endcase
    end

    always_comb begin
        if ((rd_a == acs_pkg::OP_JMP) || ((rd_a == acs_pkg::OP_JZ) && (r_acc == '0))) begin
            n_pc = ea;
        end else begin
            n_pc = pc_inc(pc_inc(r_pc));
        end
    end

    // memory port control
    always_comb begin
        mem_ctl.we   = 1'b0;
        mem_ctl.re_a = 1'b0;
        mem_ctl.re_b = 1'b0;
        mem_waddr    = AW'(acs_pkg::wrap_addr(req.address, MEM_DEPTH));
        mem_wdata    = req.value;
        mem_raddr_a  = r_pc;
        mem_raddr_b  = pc_inc(r_pc);
        if (r_state == S_FETCH) begin
            mem_waddr   = ea;
            mem_wdata   = r_acc;
            mem_raddr_a = ea;
            if (rd_a == acs_pkg::OP_STA) begin
                mem_ctl.we = 1'b1;
            end else begin
                mem_ctl.re_a = 1'b1;
            end
        end else begin
            mem_ctl.we   = accept && (req.cmd == acs_pkg::CMD_WRITE);
            mem_ctl.re_a = run;
            mem_ctl.re_b = run;
        end
    end

    acs_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // completion stage
    always_comb begin
        n_acc     = r_acc;
        x_printed = 1'b0;
        x_pval    = '0;
        case (r_op)
            acs_pkg::OP_LDI: n_acc = r_opnd;
            acs_pkg::OP_LDM: n_acc = rd_a;
            acs_pkg::OP_ADI: n_acc = r_acc + r_opnd;
            acs_pkg::OP_ADM: n_acc = r_acc + rd_a;
            acs_pkg::OP_SBI: n_acc = r_acc - r_opnd;
            acs_pkg::OP_SBM: n_acc = r_acc - rd_a;
            acs_pkg::OP_OUT: begin
                x_printed = 1'b1;
                x_pval    = rd_a;
            end
            default: n_acc = r_acc;
        endcase
    end

    assign x_rsp = '{printed: x_printed, printed_value: x_pval, halted: r_halt,
                     program_counter: 8'(r_pc), accumulator: n_acc};
    assign s_rsp = '{printed: 1'b0, printed_value: 8'd0, halted: r_halt,
                     program_counter: 8'(r_pc), accumulator: r_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_acc     <= '0;
            r_halt    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !out_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= run ? S_FETCH : S_POST;
                    end
                end
                S_FETCH: begin
                    r_state <= S_EXEC;
                    r_pc    <= n_pc;
                    r_op    <= rd_a;
                    r_opnd  <= rd_b;
                    if (!op_legal) begin
                        r_halt <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_acc     <= restart ? '0 : n_acc;
                        r_o_valid <= 1'b1;
                        r_o_data  <= x_rsp;
                        r_state   <= accept ? (run ? S_FETCH : S_POST) : S_IDLE;
                    end
                end
                S_POST: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= s_rsp;
                        r_state   <= accept ? (run ? S_FETCH : S_POST) : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // restart taken in the same cycle overrides the completing instruction
            if (restart) begin
                r_pc   <= '0;
                r_halt <= 1'b0;
                if (r_state != S_EXEC) begin
                    r_acc <= '0;
                end
            end
        end
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    `ACS_ASSERT_NXT(a_fetch_then_exec, i_clk, i_rst_n, r_state == S_FETCH, r_state == S_EXEC)
    `ACS_ASSERT_IMP(a_no_rw_port_a, i_clk, i_rst_n, mem_ctl.we, !mem_ctl.re_a)
    `ACS_ASSERT_IMP(a_no_rw_port_b, i_clk, i_rst_n, mem_ctl.we, !mem_ctl.re_b)
    `ACS_ASSERT_NXT(a_run_fetches, i_clk, i_rst_n, run, r_state == S_FETCH)
    `ACS_ASSERT_NXT(a_halted_keeps_pc, i_clk, i_rst_n,
                    accept && (req.cmd == acs_pkg::CMD_EXEC) && r_halt, $stable(r_pc))

endmodule
